// ----- rtl/bbrm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrm_pkg
// Shared types, codes and default sizes of the buddy block release/merge unit.
// ----------------------------------------------------------------------------
package bbrm_pkg;

	// default sizes
	localparam int NUM_ORDERS_DEF = 16;
	localparam int LIST_DEPTH_DEF = 64;
	localparam int ADDR_BITS_DEF  = 16;

	// width of a stored block address
	localparam int ADDR_W = 16;

	// operation codes
	localparam logic [1:0] OP_SEED    = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  order;
		logic [15:0] addr;
		logic [5:0]  index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  res_order;
		logic [15:0] res_addr;
		logic [6:0]  count;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PLAN,
		S_TAKE,
		S_PUT,
		S_READ,
		S_FIN
	} state_t;

endpackage

// ----- rtl/bbrm_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrm_req_if
// Request channel: valid/ready handshake carrying one operation.
// ----------------------------------------------------------------------------
interface bbrm_req_if;
	logic          valid;
	logic          ready;
	bbrm_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/bbrm_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrm_rsp_if
// Response channel: valid/ready handshake carrying one result.
// ----------------------------------------------------------------------------
interface bbrm_rsp_if;
	logic          valid;
	logic          ready;
	bbrm_pkg::rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/bbrm_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrm_store
// Free list storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bbrm_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/buddy_block_release_merge_unit.sv -----
`timescale 1ns / 1ps
// Buddy allocator free lists with merging on release. One sorted free list per
// order lives in a single-port-read memory; every list pass streams the list
// through that read port at one entry per cycle. A read makes no list pass, a seed
// makes one pass over the target list, and a release adds one pass for every
// order k whose list is searched for a buddy. The store has no reset and needs
// no clearing pass: reads never go past a list's count. A finished result waits
// in an output register; the next transaction is accepted while it waits.
// ----------------------------------------------------------------------------
// buddy_block_release_merge_unit
// Seed, release with buddy coalescing, and list read over sorted free lists.
// ----------------------------------------------------------------------------
module buddy_block_release_merge_unit #(
	parameter int NUM_ORDERS = bbrm_pkg::NUM_ORDERS_DEF,
	parameter int LIST_DEPTH = bbrm_pkg::LIST_DEPTH_DEF,
	parameter int ADDR_BITS  = bbrm_pkg::ADDR_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bbrm_req_if.sink   req,
	bbrm_rsp_if.source rsp
);

	localparam int KW        = $clog2(NUM_ORDERS);
	localparam int CW        = $clog2(LIST_DEPTH + 1);
	localparam int PW        = $clog2(LIST_DEPTH);
	localparam int MEM_DEPTH = NUM_ORDERS * LIST_DEPTH;
	localparam int MAW       = $clog2(MEM_DEPTH);
	localparam int DW        = bbrm_pkg::ADDR_W;
	localparam int MERGE_LIM = (ADDR_BITS < DW) ? ADDR_BITS : DW;
	localparam logic [DW-1:0] ADDR_MASK =
		(ADDR_BITS >= DW) ? {DW{1'b1}} : DW'((33'd1 << ADDR_BITS) - 33'd1);

	bbrm_pkg::state_t state_q, state_d;

	logic [1:0]    op_q;
	logic [KW-1:0] k_q;
	logic [DW-1:0] a_q;
	logic [5:0]    idx_q;
	logic          stop_q;
	logic [1:0]    status_q;
	logic [DW-1:0] raddr_q;
	logic [CW-1:0] ptr_q;
	logic          hit_q;
	logic [DW-1:0] carry_q;
	logic          vld_s1;
	logic [PW-1:0] pos_s1;
	logic [CW-1:0] cnt_q [NUM_ORDERS];
	logic          out_vld_q;
	bbrm_pkg::rsp_t out_q;

	logic [CW-1:0]  n;
	logic           put_op;
	logic           can_merge;
	logic [DW-1:0]  bit_v;
	logic [DW-1:0]  target;
	logic [MAW-1:0] base;
	logic           issue;
	logic           drained;
	logic           rd_hit;
	logic           out_free;
	logic [KW-1:0]  order_sat;
	logic           rd_en;
	logic [MAW-1:0] rd_addr;
	logic [DW-1:0]  rd_data;
	logic           wr_en;
	logic [MAW-1:0] wr_addr;
	logic [DW-1:0]  wr_data;

	// decode of the current list and merge step
	assign n         = cnt_q[k_q];
	assign put_op    = (op_q == bbrm_pkg::OP_SEED) || (op_q == bbrm_pkg::OP_RELEASE);
	assign can_merge = (int'(k_q) + 1 < NUM_ORDERS) && (int'(k_q) < MERGE_LIM);
	assign bit_v     = DW'(1) << k_q;
	assign target    = a_q ^ bit_v;
	assign base      = MAW'(int'(k_q) * LIST_DEPTH);
	assign issue     = ((state_q == bbrm_pkg::S_TAKE) || (state_q == bbrm_pkg::S_PUT))
		&& (ptr_q < n);
	assign drained   = !vld_s1 && (ptr_q >= n);
	assign rd_hit    = (int'(idx_q) < int'(n));
	assign out_free  = !out_vld_q || rsp.ready;
	assign order_sat = (int'(req.data.order) >= NUM_ORDERS) ? KW'(NUM_ORDERS - 1)
		: KW'(req.data.order);

	assign req.ready = (state_q == bbrm_pkg::S_IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	// memory read: list scan, or single entry fetch
	always_comb begin
		rd_en   = issue;
		rd_addr = base + MAW'(ptr_q[PW-1:0]);
		if (state_q == bbrm_pkg::S_PLAN) begin
			rd_en   = !put_op && rd_hit;
			rd_addr = base + MAW'(idx_q);
		end
	end

	// memory write: shift down after a removed entry, shift up for an insert
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = base + MAW'(pos_s1);
		wr_data = rd_data;
		if (state_q == bbrm_pkg::S_TAKE) begin
			wr_en   = vld_s1 && hit_q;
			wr_addr = base + MAW'(pos_s1 - PW'(1));
		end else if (state_q == bbrm_pkg::S_PUT) begin
			wr_data = hit_q ? carry_q : a_q;
			if (vld_s1) begin
				wr_en = hit_q || (rd_data >= a_q);
			end else if (drained) begin
				wr_en   = 1'b1;
				wr_addr = base + MAW'(n[PW-1:0]);
			end
		end
	end

	bbrm_store #(
		.DEPTH(MEM_DEPTH),
		.AW   (MAW),
		.DW   (DW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbrm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bbrm_pkg::S_IDLE: begin
				if (req.valid) state_d = bbrm_pkg::S_PLAN;
			end
			bbrm_pkg::S_PLAN: begin
				if (put_op) begin
					if (op_q == bbrm_pkg::OP_RELEASE && !stop_q && can_merge) begin
						state_d = bbrm_pkg::S_TAKE;
					end else if (int'(n) >= LIST_DEPTH) begin
						state_d = bbrm_pkg::S_FIN;
					end else begin
						state_d = bbrm_pkg::S_PUT;
					end
				end else if (rd_hit) begin
					state_d = bbrm_pkg::S_READ;
				end else begin
					state_d = bbrm_pkg::S_FIN;
				end
			end
			bbrm_pkg::S_TAKE: begin
				if (drained) state_d = bbrm_pkg::S_PLAN;
			end
			bbrm_pkg::S_PUT: begin
				if (drained) state_d = bbrm_pkg::S_FIN;
			end
			bbrm_pkg::S_READ: begin
				state_d = bbrm_pkg::S_FIN;
			end
			bbrm_pkg::S_FIN: begin
				if (out_free) state_d = bbrm_pkg::S_IDLE;
			end
			default: begin
				state_d = bbrm_pkg::S_IDLE;
			end
		endcase
	end

	// control registers: list counts, scan pipe valid, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '{default: '0};
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (state_q == bbrm_pkg::S_TAKE && drained && hit_q) begin
				cnt_q[k_q] <= n - CW'(1);
			end
			if (state_q == bbrm_pkg::S_PUT && drained) begin
				cnt_q[k_q] <= n + CW'(1);
			end
			if (state_q == bbrm_pkg::S_FIN && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// working registers of the current transaction
	always_ff @(posedge clk) begin
		pos_s1 <= ptr_q[PW-1:0];
		if (issue) ptr_q <= ptr_q + CW'(1);
		case (state_q)
			bbrm_pkg::S_IDLE: begin
				if (req.valid) begin
					op_q     <= req.data.op;
					k_q      <= order_sat;
					a_q      <= req.data.addr & ADDR_MASK;
					idx_q    <= req.data.index;
					stop_q   <= 1'b0;
					status_q <= bbrm_pkg::STAT_OK;
				end
			end
			bbrm_pkg::S_PLAN: begin
				ptr_q <= '0;
				hit_q <= 1'b0;
				if (put_op) begin
					if (!(op_q == bbrm_pkg::OP_RELEASE && !stop_q && can_merge)
						&& int'(n) >= LIST_DEPTH) begin
						status_q <= bbrm_pkg::STAT_FULL;
					end
				end else if (!rd_hit) begin
					status_q <= bbrm_pkg::STAT_RANGE;
					raddr_q  <= '0;
				end
			end
			bbrm_pkg::S_TAKE: begin
				if (vld_s1 && !hit_q && rd_data == target) hit_q <= 1'b1;
				if (drained) begin
					if (hit_q) begin
						a_q <= a_q & ~bit_v;
						k_q <= k_q + KW'(1);
					end else begin
						stop_q <= 1'b1;
					end
				end
			end
			bbrm_pkg::S_PUT: begin
				if (vld_s1 && (hit_q || rd_data >= a_q)) begin
					carry_q <= rd_data;
					hit_q   <= 1'b1;
				end
			end
			bbrm_pkg::S_READ: begin
				raddr_q <= rd_data;
			end
			bbrm_pkg::S_FIN: begin
				if (out_free) begin
					out_q.status    <= status_q;
					out_q.res_order <= 4'(k_q);
					out_q.res_addr  <= put_op ? a_q : raddr_q;
					out_q.count     <= 7'(n);
				end
			end
			default: begin
			end
		endcase
	end

	// memory writes happen only during list passes
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == bbrm_pkg::S_TAKE || state_q == bbrm_pkg::S_PUT))
		else $error("store written outside a list pass");

	// a list never grows past its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != bbrm_pkg::S_IDLE) |-> int'(cnt_q[k_q]) <= LIST_DEPTH)
		else $error("list count beyond depth");

	// scan pointer stays within the list being scanned
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbrm_pkg::S_TAKE || state_q == bbrm_pkg::S_PUT) |-> ptr_q <= n)
		else $error("scan pointer past list count");

	// a result appears only after finishing a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == bbrm_pkg::S_FIN))
		else $error("result raised outside finish");

	// an insert that fills a slot bumps the count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbrm_pkg::S_PUT && drained) |=> cnt_q[$past(k_q)] == $past(n) + CW'(1))
		else $error("insert count update lost");

endmodule
